[rtl/terminal_cell_color_resolver_defines.svh]
// Assertion macros shared by the resolver RTL.
`ifndef TERMINAL_CELL_COLOR_RESOLVER_DEFINES_SVH
`define TERMINAL_CELL_COLOR_RESOLVER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TCCR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tccr: assertion failed");

// Check that a condition never holds.
`define TCCR_ASSERT_NEVER(lbl, clk, rstn, prop) \
  `TCCR_ASSERT(lbl, clk, rstn, !(prop))

`endif

[rtl/tccr_pkg.sv]
package tccr_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_ACTIVE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_START   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_END     = 3'd6;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_INDEXED = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  localparam logic [31:0] SEL_BG_RGBA = 32'h3B82F6B4;
  localparam logic [31:0] WHITE_RGBA  = 32'hFFFFFFFF;
  localparam logic [7:0]  DIM_ALPHA   = 8'd140;

  localparam logic [6:0] CELL_W_MIN = 7'd4;
  localparam logic [6:0] CELL_W_MAX = 7'd64;
  localparam logic [7:0] CELL_H_MIN = 8'd8;
  localparam logic [7:0] CELL_H_MAX = 8'd128;

  localparam logic [31:0] DEFAULT_FG_RST = 32'hFFFFFFFF;
  localparam logic [31:0] DEFAULT_BG_RST = 32'h000000FF;
  localparam logic [6:0]  CELL_W_RST     = 7'd8;
  localparam logic [7:0]  CELL_H_RST     = 8'd16;

  localparam logic [31:0] ANSI16 [16] = '{
    32'h000000FF, 32'hDC2626FF, 32'h16A34AFF, 32'hCA8A04FF,
    32'h2563EBFF, 32'h9333EAFF, 32'h0D9488FF, 32'hCBD5E1FF,
    32'h64748BFF, 32'hEF4444FF, 32'h22C55EFF, 32'hEAB308FF,
    32'h3B82F6FF, 32'hA855F7FF, 32'h14B8A6FF, 32'hF8FAFCFF
  };

  typedef struct packed {
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [1:0]  cell_span;
    logic [20:0] codepoint;
    logic [1:0]  fg_kind;
    logic [23:0] fg_value;
    logic [1:0]  bg_kind;
    logic [23:0] bg_value;
    logic [3:0]  attr_bits;
  } cell_t;

  typedef struct packed {
    logic        cell_skipped;
    logic [13:0] x_start;
    logic [14:0] y_start;
    logic [14:0] x_end;
    logic [15:0] y_end;
    logic [31:0] bg_rgba;
    logic        draw_background;
    logic [31:0] fg_rgba;
    logic [31:0] glyph_rgba;
    logic        draw_glyph;
    logic [1:0]  font_style;
    logic        sel_hit;
  } result_t;

  function automatic logic [7:0] cube_level(logic [2:0] v);
    return (v == 3'd0) ? 8'd0 : 8'(8'(v) * 8'd40 + 8'd55);
  endfunction

  // Cube digits come from reciprocal multiplies, exact for k below 216.
  function automatic logic [31:0] palette256(logic [7:0] idx);
    logic [7:0]  k;
    logic [13:0] prod_r;
    logic [15:0] prod_g;
    logic [2:0]  qr;
    logic [5:0]  q6;
    logic [2:0]  qg;
    logic [2:0]  qb;
    logic [7:0]  gr;
    k      = idx - 8'd16;
    prod_r = 14'(k) * 14'd57;
    qr     = prod_r[13:11];
    prod_g = 16'(k) * 16'd171;
    q6     = prod_g[15:10];
    qg     = 3'(q6 - 6'(qr) * 6'd6);
    qb     = 3'(k - 8'(q6) * 8'd6);
    gr     = 8'((idx - 8'd232) * 8'd10 + 8'd8);
    if (idx < 8'd16) begin
      return ANSI16[idx[3:0]];
    end else if (idx <= 8'd231) begin
      return {cube_level(qr), cube_level(qg), cube_level(qb), 8'hFF};
    end else begin
      return {gr, gr, gr, 8'hFF};
    end
  endfunction

  function automatic logic [31:0] resolve(logic [1:0] kind, logic [23:0] value,
                                          logic promote, logic [31:0] dflt);
    logic [7:0] idx;
    idx = value[7:0];
    if (promote && idx < 8'd8) begin
      idx = idx + 8'd8;
    end
    case (kind)
      KIND_INDEXED: return palette256(idx);
      KIND_RGB:     return {value, 8'hFF};
      default:      return dflt;
    endcase
  endfunction

endpackage

[rtl/tccr_if.sv]
interface tccr_cell_if;
  logic           valid;
  logic           ready;
  tccr_pkg::cell_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccr_result_if;
  logic             valid;
  logic             ready;
  tccr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/terminal_cell_color_resolver.sv]
// Channel   Dir  Payload               Transaction
// cell_i    in   tccr_pkg::cell_t      valid && ready at rising clk_i
// res_o     out  tccr_pkg::result_t    valid && ready at rising clk_i
// cfg       in   cfg_idx_i, cfg_wdata_i written when cfg_we_i is high
//
// Two register stages: input register, then result register.
// One cell per cycle sustained while res_o is ready; multiply, palette
// lookup and selection compare run in a single pass between the two registers.
// rst_ni clears both stage valids and resets the configuration registers to their defaults.
// A stalled result holds the result register; the input register keeps taking
// cells while it is empty or the result register is free or drains in that cycle.
`include "terminal_cell_color_resolver_defines.svh"

module terminal_cell_color_resolver #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tccr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  tccr_cell_if.sink                      cell_i,
  tccr_result_if.source                  res_o
);

  localparam logic [8:0] ROW_LIMIT = 9'(MAX_ROWS);
  localparam logic [8:0] COL_LIMIT = 9'(MAX_COLS);

  logic [31:0] dflt_fg_q;
  logic [31:0] dflt_bg_q;
  logic [6:0]  cell_w_q;
  logic [7:0]  cell_h_q;
  logic        sel_active_q;
  logic [15:0] sel_start_q;
  logic [15:0] sel_end_q;

  tccr_pkg::cell_t   in_q;
  logic              in_valid_q;
  tccr_pkg::result_t res_q, res_d;
  logic              res_valid_q;
  logic              adv;

  logic        skip;
  logic [1:0]  span_eff;
  logic [14:0] x0;
  logic [14:0] y0;
  logic [7:0]  x_len;
  logic [31:0] bg_raw, fg_raw, bg_sw, fg_sw, bg_fin, fg_fin;
  logic        bold, italic, dim, rev;
  logic        sel;
  logic [7:0]  sr, sc, er, ec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_fg_q    <= tccr_pkg::DEFAULT_FG_RST;
      dflt_bg_q    <= tccr_pkg::DEFAULT_BG_RST;
      cell_w_q     <= tccr_pkg::CELL_W_RST;
      cell_h_q     <= tccr_pkg::CELL_H_RST;
      sel_active_q <= 1'b0;
      sel_start_q  <= '0;
      sel_end_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccr_pkg::CFG_DEFAULT_FG: dflt_fg_q <= cfg_wdata_i;
        tccr_pkg::CFG_DEFAULT_BG: dflt_bg_q <= cfg_wdata_i;
        tccr_pkg::CFG_CELL_WIDTH: begin
          if (cfg_wdata_i[6:0] < tccr_pkg::CELL_W_MIN) begin
            cell_w_q <= tccr_pkg::CELL_W_MIN;
          end else if (cfg_wdata_i[6:0] > tccr_pkg::CELL_W_MAX) begin
            cell_w_q <= tccr_pkg::CELL_W_MAX;
          end else begin
            cell_w_q <= cfg_wdata_i[6:0];
          end
        end
        tccr_pkg::CFG_CELL_HEIGHT: begin
          if (cfg_wdata_i[7:0] < tccr_pkg::CELL_H_MIN) begin
            cell_h_q <= tccr_pkg::CELL_H_MIN;
          end else if (cfg_wdata_i[7:0] > tccr_pkg::CELL_H_MAX) begin
            cell_h_q <= tccr_pkg::CELL_H_MAX;
          end else begin
            cell_h_q <= cfg_wdata_i[7:0];
          end
        end
        tccr_pkg::CFG_SEL_ACTIVE: sel_active_q <= cfg_wdata_i[0];
        tccr_pkg::CFG_SEL_START:  sel_start_q  <= cfg_wdata_i[15:0];
        tccr_pkg::CFG_SEL_END:    sel_end_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign adv          = in_valid_q && (!res_valid_q || res_o.ready);
  assign cell_i.ready = !in_valid_q || adv;
  assign res_o.valid  = res_valid_q;
  assign res_o.data   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cell_i.ready) begin
        in_valid_q <= cell_i.valid;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_i.valid && cell_i.ready) begin
      in_q <= cell_i.data;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign bold   = in_q.attr_bits[0];
  assign italic = in_q.attr_bits[1];
  assign dim    = in_q.attr_bits[2];
  assign rev    = in_q.attr_bits[3];

  assign skip = (in_q.cell_span == 2'd0) || ({1'b0, in_q.cell_row} >= ROW_LIMIT)
             || ({1'b0, in_q.cell_col} >= COL_LIMIT);

  assign span_eff = in_q.cell_span[1] ? 2'd2 : in_q.cell_span;
  assign x0       = 15'(in_q.cell_col) * 15'(cell_w_q);
  assign y0       = 15'(in_q.cell_row) * 15'(cell_h_q);
  assign x_len    = (span_eff == 2'd2) ? {cell_w_q, 1'b0} : {1'b0, cell_w_q};

  assign bg_raw = tccr_pkg::resolve(in_q.bg_kind, in_q.bg_value, 1'b0, dflt_bg_q);
  assign fg_raw = tccr_pkg::resolve(in_q.fg_kind, in_q.fg_value, bold, dflt_fg_q);
  assign bg_sw  = rev ? fg_raw : bg_raw;
  assign fg_sw  = rev ? bg_raw : fg_raw;

  assign sr = sel_start_q[15:8];
  assign sc = sel_start_q[7:0];
  assign er = sel_end_q[15:8];
  assign ec = sel_end_q[7:0];

  always_comb begin
    sel = 1'b0;
    if (sel_active_q && in_q.cell_row >= sr && in_q.cell_row <= er) begin
      if (sr == er) begin
        sel = (in_q.cell_col >= sc) && (in_q.cell_col <= ec);
      end else if (in_q.cell_row == sr) begin
        sel = in_q.cell_col >= sc;
      end else if (in_q.cell_row == er) begin
        sel = in_q.cell_col <= ec;
      end else begin
        sel = 1'b1;
      end
    end
  end

  assign bg_fin = sel ? tccr_pkg::SEL_BG_RGBA : bg_sw;
  assign fg_fin = sel ? tccr_pkg::WHITE_RGBA : fg_sw;

  always_comb begin
    res_d = '0;
    if (skip) begin
      res_d.cell_skipped = 1'b1;
    end else begin
      res_d.x_start         = x0[13:0];
      res_d.y_start         = y0;
      res_d.x_end           = 15'(x0 + 15'(x_len));
      res_d.y_end           = 16'(16'(y0) + 16'(cell_h_q));
      res_d.bg_rgba         = bg_fin;
      res_d.draw_background = (bg_fin != dflt_bg_q) || sel;
      res_d.fg_rgba         = fg_fin;
      res_d.glyph_rgba      = dim ? {fg_fin[31:8], tccr_pkg::DIM_ALPHA} : fg_fin;
      res_d.draw_glyph      = (in_q.codepoint != 21'd0) && (in_q.codepoint != 21'd32);
      res_d.font_style      = {italic, bold};
      res_d.sel_hit         = sel;
    end
  end

  `TCCR_ASSERT(a_adv_fills_result, clk_i, rst_ni, adv |=> res_valid_q)
  `TCCR_ASSERT(a_skip_clears, clk_i, rst_ni,
    (res_valid_q && res_q.cell_skipped) |->
      (res_q.bg_rgba == 32'd0 && res_q.draw_glyph == 1'b0 && res_q.x_end == 15'd0))
  `TCCR_ASSERT(a_sel_override, clk_i, rst_ni,
    (res_valid_q && res_q.sel_hit) |->
      (res_q.draw_background && res_q.bg_rgba == tccr_pkg::SEL_BG_RGBA))
  `TCCR_ASSERT_NEVER(a_rect_order, clk_i, rst_ni,
    res_valid_q && !res_q.cell_skipped &&
      ({1'b0, res_q.x_start} >= res_q.x_end || {1'b0, res_q.y_start} >= res_q.y_end))

endmodule
